[hw/rtl/button_debounce_click_classifier_macros.svh]
// Assertion macros for the button debounce and click classifier.
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define BDCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BDCC_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDCC_ASSERT(lbl, prop, msg)
`define BDCC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/bdcc_pkg.sv]
// Types and constants of the button debounce and click classifier.
package bdcc_pkg;

    localparam int STABLE_W = 8;
    localparam int TICK_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_CLICK_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WAIT_TICKS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [STABLE_W-1:0] STABLE_TICKS_RST      = 8'd10;
    localparam logic [TICK_W-1:0]   LONG_CLICK_TICKS_RST  = 16'd1000;
    localparam logic [TICK_W-1:0]   DOUBLE_WAIT_TICKS_RST = 16'd100;

    localparam logic [STABLE_W-1:0] STABLE_MAX = {STABLE_W{1'b1}};
    localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};

    // Click phase codes
    localparam logic [1:0] PHASE_IDLE         = 2'd0;
    localparam logic [1:0] PHASE_IN_CLICK     = 2'd1;
    localparam logic [1:0] PHASE_MAYBE_DOUBLE = 2'd2;

    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic level;
        logic pressed_edge;
        logic released_edge;
        logic long_click;
        logic double_click;
    } click_result_t;

endpackage

[hw/rtl/button_debounce_click_classifier.sv]
// Button debounce and click classifier: one raw sample per tick, one result per sample.
// A result is registered: it shows on the outputs in the cycle after its sample transfers.
// Throughput: one sample per cycle while a waiting result is not held by out_stall; the
// debounce, counter and phase update is one pass of compare-and-increment logic between the state and result registers.
// Reset (rst_n, async, active low): released level, idle phase, counters zero,
// configuration back to 10 / 1000 / 100 ticks, result register empty.
module button_debounce_click_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [bdcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdcc_pkg::CFG_W-1:0]          cfg_data,
    // sample channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                raw_level,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                level,
    output logic                                pressed_edge,
    output logic                                released_edge,
    output logic                                long_click,
    output logic                                double_click
);
    import bdcc_pkg::*;

`include "button_debounce_click_classifier_macros.svh"

    // Configuration registers
    logic [STABLE_W-1:0] stable_ticks_reg;
    logic [TICK_W-1:0]   long_click_ticks_reg;
    logic [TICK_W-1:0]   double_wait_ticks_reg;

    // Debounce and click state
    logic                candidate_reg, candidate_next;
    logic [STABLE_W-1:0] stable_count_reg, stable_count_next;
    logic                accepted_reg, accepted_next;
    logic [1:0]          phase_reg, phase_next;
    logic [TICK_W-1:0]   since_press_reg, since_press_next;
    logic [TICK_W-1:0]   since_release_reg, since_release_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    click_result_t       result_reg, result_next;

    logic                in_xfer;
    logic                edge_hit;
    logic [TICK_W-1:0]   press_inc;
    logic [TICK_W-1:0]   release_inc;

    // Hold the sample only while a finished result waits and is not taken
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_ticks_reg      <= STABLE_TICKS_RST;
            long_click_ticks_reg  <= LONG_CLICK_TICKS_RST;
            double_wait_ticks_reg <= DOUBLE_WAIT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STABLE_TICKS:      stable_ticks_reg      <= cfg_data[STABLE_W-1:0];
                CFG_LONG_CLICK_TICKS:  long_click_ticks_reg  <= cfg_data[TICK_W-1:0];
                CFG_DOUBLE_WAIT_TICKS: double_wait_ticks_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // One tick of the debounce and click classification
    always_comb
    begin
        // Elapsed counters advance first, saturating
        press_inc   = (since_press_reg != TICK_MAX) ? since_press_reg + 1'b1
                                                    : since_press_reg;
        release_inc = (since_release_reg != TICK_MAX) ? since_release_reg + 1'b1
                                                      : since_release_reg;
        since_press_next   = press_inc;
        since_release_next = release_inc;

        // Track the candidate level and how long it has held
        if (raw_level == candidate_reg)
        begin
            candidate_next    = candidate_reg;
            stable_count_next = (stable_count_reg != STABLE_MAX) ?
                                stable_count_reg + 1'b1 : stable_count_reg;
        end
        else
        begin
            candidate_next    = raw_level;
            stable_count_next = {{(STABLE_W-1){1'b0}}, 1'b1};
        end

        edge_hit = (stable_count_next >= stable_ticks_reg) &&
                   (candidate_next != accepted_reg);

        accepted_next = accepted_reg;
        phase_next    = phase_reg;
        result_next   = '0;

        if (edge_hit)
        begin
            accepted_next = candidate_next;
            if (candidate_next == LEVEL_RELEASED)
            begin
                // Release: judge the press length before the release counter clears
                result_next.released_edge = 1'b1;
                if (phase_reg == PHASE_IN_CLICK)
                begin
                    if (press_inc >= long_click_ticks_reg)
                    begin
                        result_next.long_click = 1'b1;
                        phase_next = PHASE_IDLE;
                    end
                    else
                    begin
                        phase_next = PHASE_MAYBE_DOUBLE;
                    end
                end
                since_release_next = '0;
            end
            else
            begin
                // Press: a pending double-click wait completes here
                result_next.pressed_edge = 1'b1;
                if (phase_reg == PHASE_MAYBE_DOUBLE)
                begin
                    result_next.double_click = 1'b1;
                    phase_next = PHASE_IDLE;
                end
                else if (phase_reg != PHASE_IN_CLICK)
                begin
                    // idle, or the unused code treated as idle
                    phase_next = PHASE_IN_CLICK;
                end
                since_press_next = '0;
            end
        end
        else if (phase_reg == PHASE_MAYBE_DOUBLE &&
                 release_inc >= double_wait_ticks_reg)
        begin
            // Wait for a second press ran out
            phase_next = PHASE_IDLE;
        end

        result_next.level = accepted_next;

        // Result register fills on a sample transfer, empties when taken
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State advances only on a sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            candidate_reg     <= LEVEL_RELEASED;
            stable_count_reg  <= '0;
            accepted_reg      <= LEVEL_RELEASED;
            phase_reg         <= PHASE_IDLE;
            since_press_reg   <= '0;
            since_release_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                candidate_reg     <= candidate_next;
                stable_count_reg  <= stable_count_next;
                accepted_reg      <= accepted_next;
                phase_reg         <= phase_next;
                since_press_reg   <= since_press_next;
                since_release_reg <= since_release_next;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign level         = result_reg.level;
    assign pressed_edge  = result_reg.pressed_edge;
    assign released_edge = result_reg.released_edge;
    assign long_click    = result_reg.long_click;
    assign double_click  = result_reg.double_click;

    // A press and a release never land on the same tick
    `BDCC_ASSERT_NEVER(a_one_edge, out_valid_reg && result_reg.pressed_edge && result_reg.released_edge, "press and release flagged together")
    // Click events ride on their edges
    `BDCC_ASSERT(a_click_on_edge, out_valid_reg |-> ((!result_reg.long_click || result_reg.released_edge) && (!result_reg.double_click || result_reg.pressed_edge)), "click flag without its edge")
    // The shown level matches the debounce state after that sample
    `BDCC_ASSERT(a_level_track, out_valid_reg |-> (result_reg.level == accepted_reg), "result level disagrees with state")
    // A transferred sample always leaves a result waiting
    `BDCC_ASSERT(a_result_fill, in_xfer |=> out_valid_reg, "sample transferred without a result")

endmodule
